// File: design/rsp_pkg.sv
// Shared types, constants and helpers of the register script parser.
// Used by rsp_parser, rsp_out_fifo and register_script_parser_core.
`timescale 1ns / 1ps

package rsp_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int BYTE_W          = 8;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 24;
    localparam int M_TUSER_W       = 4;

    localparam logic [BYTE_W-1:0] CMD_DELAY = 8'hFE;
    localparam logic [BYTE_W-1:0] CMD_BURST = 8'hFD;
    localparam logic [BYTE_W-1:0] CMD_SKIP  = 8'hF0;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_WRITE = 3'd0,
        KIND_BURST = 3'd1,
        KIND_DELAY = 3'd2,
        KIND_DONE  = 3'd3,
        KIND_ERROR = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_EMPTY  = 2'd2
    } t_err;

    typedef enum logic [7:0] {
        PH_CMD     = 8'b0000_0001,
        PH_VALUE   = 8'b0000_0010,
        PH_DELAY   = 8'b0000_0100,
        PH_BLEN    = 8'b0000_1000,
        PH_BREG    = 8'b0001_0000,
        PH_BDATA   = 8'b0010_0000,
        PH_SKIPLEN = 8'b0100_0000,
        PH_SKIP    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] data_value;
        logic              burst_first;
        logic              burst_last;
        t_err              error_code;
    } t_result;

    // up to two results per script byte, res0 first
    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_push;

    function automatic t_result make_result(input t_kind kind, input logic [BYTE_W-1:0] addr,
                                            input logic [BYTE_W-1:0] data, input logic first,
                                            input logic last, input t_err err);
        t_result r;
        r.kind        = kind;
        r.reg_addr    = addr;
        r.data_value  = data;
        r.burst_first = first;
        r.burst_last  = last;
        r.error_code  = err;
        return r;
    endfunction

endpackage

// File: design/register_script_parser_core.sv
// Register script parser top level: input register, parser, result queue.
// A byte is registered at transfer; its results are then written to the queue.
// Throughput: one byte per cycle while the queue has room; one result per transfer.
// The only two-result byte is the one that also ends the script.
// Reset (synchronous, active low) clears parse state, sets script length to 1
// and empties the queue; a configuration write also restarts parsing.
`timescale 1ns / 1ps

module register_script_parser_core #(
    parameter int LENGTH_BITS = rsp_pkg::LENGTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: script_bytes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsp_pkg::CFG_W-1:0]       i_cfg_data,
    // tdata: script_byte[7:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rsp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tdata: reg_addr[7:0], data_value[15:8], error_code[17:16], zero pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rsp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: kind[2:0], burst_first[3]
    output logic [rsp_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                            m_axis_tlast
);
    import rsp_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              room;
    logic              step;
    logic              in_xfer;
    logic              cfg_we;
    t_push             push;
    t_result           res;

    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid;
    assign step          = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || room;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= s_axis_tdata[BYTE_W-1:0];
        end
    end

    rsp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .o_push     (push)
    );

    rsp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {6'b000000, res.error_code, res.data_value, res.reg_addr};
    assign m_axis_tuser = {res.burst_first, res.kind};
    assign m_axis_tlast = res.burst_last;

endmodule

// File: design/rsp_parser.sv
// Script byte parser: phase state and per-byte result generation.
// Depends on rsp_pkg.
`timescale 1ns / 1ps

module rsp_parser #(
    parameter int LENGTH_BITS = rsp_pkg::LENGTH_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rsp_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_step,
    input  logic [rsp_pkg::BYTE_W-1:0]   i_byte,
    output rsp_pkg::t_push               o_push
);
    import rsp_pkg::*;

    localparam int EXT_W = LENGTH_BITS + 2;

    logic [LENGTH_BITS-1:0] r_script_bytes;
    logic [LENGTH_BITS-1:0] r_seen,  n_seen;
    t_phase                 r_phase, n_phase;
    logic [BYTE_W-1:0]      r_held,  n_held;
    logic [BYTE_W-1:0]      r_blft,  n_blft;
    logic [BYTE_W-1:0]      r_skip,  n_skip;
    logic                   r_started, n_started;
    logic                   r_fin,   n_fin;

    logic [EXT_W-1:0]  ext_pos;
    logic [EXT_W-1:0]  ext_sb;
    logic [EXT_W-1:0]  pos_inc;
    logic              cmd_trunc;
    logic              blen_bad;
    logic [BYTE_W-1:0] blft_dec;
    logic [BYTE_W-1:0] skip_dec;
    logic              do_cmd;
    logic              case_vld;
    t_result           case_res;
    logic              done_now;
    t_result           done_res;

    assign ext_pos   = EXT_W'(r_seen);
    assign ext_sb    = EXT_W'(r_script_bytes);
    assign pos_inc   = ext_pos + EXT_W'(1);
    assign cmd_trunc = (ext_pos + ((i_byte == CMD_BURST) ? EXT_W'(2) : EXT_W'(1))) >= ext_sb;
    assign blen_bad  = (i_byte == '0) || ((pos_inc + EXT_W'(i_byte)) > ext_sb);
    assign blft_dec  = (r_blft != '0) ? r_blft - BYTE_W'(1) : r_blft;
    assign skip_dec  = (r_skip != '0) ? r_skip - BYTE_W'(1) : r_skip;
    assign done_res  = make_result(KIND_DONE, '0, '0, 1'b0, 1'b0, ERR_NONE);

    always_comb begin
        n_seen    = r_seen;
        n_phase   = r_phase;
        n_held    = r_held;
        n_blft    = r_blft;
        n_skip    = r_skip;
        n_started = r_started;
        n_fin     = r_fin;
        do_cmd    = 1'b0;
        case_vld  = 1'b0;
        case_res  = '0;
        done_now  = 1'b0;
        o_push    = '0;

        if (i_step && !r_fin) begin
            case (r_phase)
                PH_VALUE: begin
                    case_vld = 1'b1;
                    case_res = make_result(KIND_WRITE, r_held, i_byte, 1'b0, 1'b0, ERR_NONE);
                    n_phase  = PH_CMD;
                end
                PH_DELAY: begin
                    case_vld = 1'b1;
                    case_res = make_result(KIND_DELAY, '0, i_byte, 1'b0, 1'b0, ERR_NONE);
                    n_phase  = PH_CMD;
                end
                PH_BLEN: begin
                    if (blen_bad) begin
                        case_vld = 1'b1;
                        case_res = make_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_LENGTH);
                        n_fin    = 1'b1;
                        n_phase  = PH_CMD;
                    end else begin
                        n_blft  = i_byte - BYTE_W'(1);
                        n_phase = PH_BREG;
                    end
                end
                PH_BREG: begin
                    if (r_blft == '0) begin
                        case_vld = 1'b1;
                        case_res = make_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_EMPTY);
                        n_fin    = 1'b1;
                        n_phase  = PH_CMD;
                    end else begin
                        n_held    = i_byte;
                        n_started = 1'b0;
                        n_phase   = PH_BDATA;
                    end
                end
                PH_BDATA: begin
                    case_vld  = 1'b1;
                    case_res  = make_result(KIND_BURST, r_held, i_byte, !r_started,
                                            r_blft == BYTE_W'(1), ERR_NONE);
                    n_started = 1'b1;
                    n_blft    = blft_dec;
                    if (blft_dec == '0) begin
                        n_phase = PH_CMD;
                    end
                end
                PH_SKIPLEN: begin
                    if (i_byte == '0) begin
                        // length byte doubles as the next command
                        do_cmd = 1'b1;
                    end else if (i_byte == BYTE_W'(1)) begin
                        n_phase = PH_CMD;
                    end else begin
                        n_skip  = i_byte - BYTE_W'(1);
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = PH_CMD;
                    end
                end
                default: begin
                    do_cmd = 1'b1;
                end
            endcase

            if (do_cmd) begin
                if (cmd_trunc) begin
                    case_vld = 1'b1;
                    case_res = make_result(KIND_ERROR, '0, '0, 1'b0, 1'b0, ERR_LENGTH);
                    n_fin    = 1'b1;
                    n_phase  = PH_CMD;
                end else if (i_byte == CMD_DELAY) begin
                    n_phase = PH_DELAY;
                end else if (i_byte == CMD_BURST) begin
                    n_phase = PH_BLEN;
                end else if (i_byte == CMD_SKIP) begin
                    n_phase = PH_SKIPLEN;
                end else begin
                    n_held  = i_byte;
                    n_phase = PH_VALUE;
                end
            end

            n_seen = pos_inc[LENGTH_BITS-1:0];
            if (!n_fin && (pos_inc >= ext_sb)) begin
                done_now = 1'b1;
                n_fin    = 1'b1;
                n_phase  = PH_CMD;
            end

            if (case_vld) begin
                o_push.res0  = case_res;
                o_push.res1  = done_res;
                o_push.count = done_now ? 2'd2 : 2'd1;
            end else begin
                o_push.res0  = done_res;
                o_push.count = done_now ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_script_bytes <= i_rst_n ? LENGTH_BITS'(i_cfg_data) : LENGTH_BITS'(1);
            r_seen         <= '0;
            r_phase        <= PH_CMD;
            r_held         <= '0;
            r_blft         <= '0;
            r_skip         <= '0;
            r_started      <= 1'b0;
            r_fin          <= 1'b0;
        end else begin
            r_seen    <= n_seen;
            r_phase   <= n_phase;
            r_held    <= n_held;
            r_blft    <= n_blft;
            r_skip    <= n_skip;
            r_started <= n_started;
            r_fin     <= n_fin;
        end
    end

endmodule

// File: design/rsp_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
// Depends on rsp_pkg.
`timescale 1ns / 1ps

module rsp_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsp_pkg::t_push    i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output rsp_pkg::t_result  o_res
);
    import rsp_pkg::*;

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count,  n_count;
    logic                    pop;
    logic [FIFO_PTR_W-1:0]   wr_ptr1;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = r_wr_ptr + FIFO_PTR_W'(1);

    assign n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
    assign n_count  = r_count + FIFO_CNT_W'(i_push.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
